@@ sv/adsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the curved ADSR envelope unit.
// No dependencies.
package adsr_pkg;

  localparam int LEN_BITS   = 24;
  localparam int CURVE_BITS = 4;
  localparam int SEG_BITS   = 3;
  localparam int IDX_BITS   = 3;

  localparam logic [LEN_BITS-1:0] RST_ATTACK_LEN  = 24'd144;
  localparam logic [LEN_BITS-1:0] RST_DECAY_LEN   = 24'd240;
  localparam logic [LEN_BITS-1:0] RST_SUSTAIN_LEN = 24'd47616;
  localparam logic [LEN_BITS-1:0] RST_RELEASE_LEN = 24'd12000;

  typedef enum logic [SEG_BITS-1:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SUSTAIN = 3'd2,
    SEG_RELEASE = 3'd3,
    SEG_DONE    = 3'd4
  } seg_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_ATTACK_LEN    = 3'd0,
    REG_DECAY_LEN     = 3'd1,
    REG_SUSTAIN_LEN   = 3'd2,
    REG_RELEASE_LEN   = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_ATTACK_CURVE  = 3'd5,
    REG_DECAY_CURVE   = 3'd6,
    REG_RELEASE_CURVE = 3'd7
  } cfg_reg_t;

endpackage

@@ sv/curved_adsr_envelope_unit.sv @@
`timescale 1ns / 1ps
// Curved ADSR envelope unit: one level per sample time transaction.
// The pipeline depth is set by one divider stage per result bit and one
// square-root stage per result bit in each curve step.
// Throughput is one transaction per cycle; a stalled result holds the pipeline.
// Synchronous reset clears the valid bits and loads the register defaults.
module curved_adsr_envelope_unit import adsr_pkg::*; #(
  parameter int TIME_BITS       = 26,
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int MAX_CURVE       = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [IDX_BITS-1:0]     cfg_index,
  input  logic [((LEVEL_FRAC_BITS + 1 > LEN_BITS) ? LEVEL_FRAC_BITS + 1 : LEN_BITS)-1:0]
                                  cfg_data,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  logic [TIME_BITS-1:0]    sample_time,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [LEVEL_FRAC_BITS:0] level,
  output logic [SEG_BITS-1:0]     segment
);

  localparam int F   = LEVEL_FRAC_BITS;
  localparam int CW  = $clog2(MAX_CURVE + 1) + 1;
  localparam int EW  = (TIME_BITS > LEN_BITS + 2) ? TIME_BITS : LEN_BITS + 2;
  localparam int TW  = SEG_BITS + F + 1;
  localparam int DTW = CW + TW;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [F:0] RST_SUSTAIN_LEVEL = ONE - (ONE >> 3);
  localparam logic signed [7:0] MAXC = 8'(MAX_CURVE);

  function automatic logic signed [CW-1:0] sat_curve(input logic [CURVE_BITS-1:0] r);
    logic signed [7:0] x;
    x = {{(8-CURVE_BITS){r[CURVE_BITS-1]}}, r};
    if (x > MAXC) begin
      x = MAXC;
    end else if (x < -MAXC) begin
      x = -MAXC;
    end
    return CW'(x);
  endfunction

  logic en;
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  logic [LEN_BITS-1:0]   attack_len, decay_len, sustain_len, release_len;
  logic [F:0]            sustain_level;
  logic [CURVE_BITS-1:0] attack_curve, decay_curve, release_curve;
  logic [EW-1:0]         e1, e2, e3, e4;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len    <= RST_ATTACK_LEN;
      decay_len     <= RST_DECAY_LEN;
      sustain_len   <= RST_SUSTAIN_LEN;
      release_len   <= RST_RELEASE_LEN;
      sustain_level <= RST_SUSTAIN_LEVEL;
      attack_curve  <= '0;
      decay_curve   <= '0;
      release_curve <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ATTACK_LEN:    attack_len    <= cfg_data[LEN_BITS-1:0];
        REG_DECAY_LEN:     decay_len     <= cfg_data[LEN_BITS-1:0];
        REG_SUSTAIN_LEN:   sustain_len   <= cfg_data[LEN_BITS-1:0];
        REG_RELEASE_LEN:   release_len   <= cfg_data[LEN_BITS-1:0];
        REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[F:0];
        REG_ATTACK_CURVE:  attack_curve  <= cfg_data[CURVE_BITS-1:0];
        REG_DECAY_CURVE:   decay_curve   <= cfg_data[CURVE_BITS-1:0];
        REG_RELEASE_CURVE: release_curve <= cfg_data[CURVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    e1 <= EW'(attack_len);
    e2 <= EW'(attack_len) + EW'(decay_len);
    e3 <= EW'(attack_len) + EW'(decay_len) + EW'(sustain_len);
    e4 <= EW'(attack_len) + EW'(decay_len) + EW'(sustain_len) + EW'(release_len);
  end

  logic                 va;
  logic [TIME_BITS-1:0] t;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t <= sample_time;
    end
  end

  logic [EW-1:0]         te;
  logic [F:0]            s_sat;
  seg_t                  seg_b_next;
  logic [EW-1:0]         off_b_next;
  logic [LEN_BITS-1:0]   len_b_next;
  logic signed [CW-1:0]  c_b_next;

  assign te    = EW'(t);
  assign s_sat = (sustain_level > ONE) ? ONE : sustain_level;

  always_comb begin
    if (te < e1) begin
      seg_b_next = SEG_ATTACK;
      off_b_next = te;
      len_b_next = attack_len;
      c_b_next   = sat_curve(attack_curve);
    end else if (te < e2) begin
      seg_b_next = SEG_DECAY;
      off_b_next = te - e1;
      len_b_next = decay_len;
      c_b_next   = sat_curve(decay_curve);
    end else if (te < e3) begin
      seg_b_next = SEG_SUSTAIN;
      off_b_next = '0;
      len_b_next = sustain_len;
      c_b_next   = '0;
    end else if (te < e4) begin
      seg_b_next = SEG_RELEASE;
      off_b_next = te - e3;
      len_b_next = release_len;
      c_b_next   = sat_curve(release_curve);
    end else begin
      seg_b_next = SEG_DONE;
      off_b_next = '0;
      len_b_next = release_len;
      c_b_next   = '0;
    end
  end

  logic                vb;
  logic [LEN_BITS-1:0] off_b, len_b;
  logic [DTW-1:0]      tag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_b <= off_b_next[LEN_BITS-1:0];
      len_b <= len_b_next;
      tag_b <= {c_b_next, seg_b_next, s_sat};
    end
  end

  logic           vd;
  logic [F-1:0]   qd;
  logic [DTW-1:0] tag_d;

  adsr_div #(.F(F), .TW(DTW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vb),
    .off      (off_b),
    .len      (len_b),
    .tag_in   (tag_b),
    .out_valid(vd),
    .quot     (qd),
    .tag_out  (tag_d)
  );

  logic                 cv [0:MAX_CURVE];
  logic [F-1:0]         cu [0:MAX_CURVE];
  logic signed [CW-1:0] cc [0:MAX_CURVE];
  logic [TW-1:0]        ct [0:MAX_CURVE];

  assign cv[0] = vd;
  assign cu[0] = qd;
  assign cc[0] = tag_d[DTW-1 -: CW];
  assign ct[0] = tag_d[TW-1:0];

  for (genvar k = 0; k < MAX_CURVE; k++) begin : g_curve
    adsr_curve #(.F(F), .CW(CW), .K(k), .TW(TW)) u_curve (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[k]),
      .u_in     (cu[k]),
      .c_in     (cc[k]),
      .tag_in   (ct[k]),
      .out_valid(cv[k+1]),
      .u_out    (cu[k+1]),
      .c_out    (cc[k+1]),
      .tag_out  (ct[k+1])
    );
  end

  logic [F-1:0]   p_c;
  logic [F:0]     s_c;
  seg_t           seg_c;
  logic [F:0]     mul_a;
  logic [2*F:0]   prod_full;

  assign p_c       = cu[MAX_CURVE];
  assign s_c       = ct[MAX_CURVE][F:0];
  assign seg_c     = seg_t'(ct[MAX_CURVE][TW-1 -: SEG_BITS]);
  assign mul_a     = (seg_c == SEG_DECAY) ? ONE - s_c : s_c;
  assign prod_full = mul_a * p_c;

  logic       vm;
  logic [F-1:0] p_m;
  logic [F:0] s_m, prod_m;
  seg_t       seg_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= cv[MAX_CURVE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_m    <= p_c;
      s_m    <= s_c;
      seg_m  <= seg_c;
      prod_m <= prod_full[2*F:F];
    end
  end

  logic [F:0] level_next;

  always_comb begin
    case (seg_m)
      SEG_ATTACK:  level_next = {1'b0, p_m};
      SEG_DECAY:   level_next = ONE - prod_m;
      SEG_SUSTAIN: level_next = s_m;
      SEG_RELEASE: level_next = s_m - prod_m;
      default:     level_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level   <= level_next;
      segment <= seg_m;
    end
  end

endmodule

@@ sv/adsr_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: quotient of off * 2^F / len, one bit a stage.
// Depends on adsr_pkg.
module adsr_div import adsr_pkg::*; #(
  parameter int F  = 16,
  parameter int TW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [LEN_BITS-1:0] off,
  input  logic [LEN_BITS-1:0] len,
  input  logic [TW-1:0]       tag_in,
  output logic                out_valid,
  output logic [F-1:0]        quot,
  output logic [TW-1:0]       tag_out
);

  logic                vl  [0:F];
  logic [LEN_BITS-1:0] rem [0:F];
  logic [LEN_BITS-1:0] dv  [0:F];
  logic [F-1:0]        qt  [0:F];
  logic [TW-1:0]       tg  [0:F];

  assign vl[0]  = in_valid;
  assign rem[0] = off;
  assign dv[0]  = len;
  assign qt[0]  = '0;
  assign tg[0]  = tag_in;

  for (genvar i = 0; i < F; i++) begin : g_step
    logic [LEN_BITS:0] dbl;
    logic              ge;
    assign dbl = {rem[i], 1'b0};
    assign ge  = dbl >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? LEN_BITS'(dbl - {1'b0, dv[i]}) : dbl[LEN_BITS-1:0];
        dv[i+1]  <= dv[i];
        qt[i+1]  <= {qt[i][F-2:0], ge};
        tg[i+1]  <= tg[i];
      end
    end
  end

  assign out_valid = vl[F];
  assign quot      = qt[F];
  assign tag_out   = tg[F];

endmodule

@@ sv/adsr_curve.sv @@
`timescale 1ns / 1ps
// One curve step: squares the position, takes its square root, or passes it,
// depending on the curve exponent and this step's place K in the chain.
// No package dependencies.
module adsr_curve #(
  parameter int F  = 16,
  parameter int CW = 4,
  parameter int K  = 0,
  parameter int TW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [F-1:0]         u_in,
  input  logic signed [CW-1:0] c_in,
  input  logic [TW-1:0]        tag_in,
  output logic                 out_valid,
  output logic [F-1:0]         u_out,
  output logic signed [CW-1:0] c_out,
  output logic [TW-1:0]        tag_out
);

  localparam logic signed [CW-1:0] KS = CW'(K);

  logic                 vl   [0:F];
  logic [F+1:0]         rem  [0:F];
  logic [F-1:0]         root [0:F];
  logic [F-1:0]         alt  [0:F];
  logic                 neg  [0:F];
  logic [F-1:0]         uk   [0:F];
  logic signed [CW-1:0] cc   [0:F];
  logic [TW-1:0]        tg   [0:F];
  logic [2*F-1:0]       sq;

  assign sq      = u_in * u_in;
  assign vl[0]   = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign alt[0]  = (c_in > KS) ? sq[2*F-1:F] : u_in;
  assign neg[0]  = c_in < -KS;
  assign uk[0]   = u_in;
  assign cc[0]   = c_in;
  assign tg[0]   = tag_in;

  for (genvar j = 0; j < F; j++) begin : g_step
    logic [2*F-1:0] rad;
    logic [1:0]     pair;
    logic [F+3:0]   cand;
    logic [F+3:0]   trial;
    logic           ge;
    assign rad   = {uk[j], {F{1'b0}}};
    assign pair  = rad[2*F-1-2*j -: 2];
    assign cand  = {rem[j], pair};
    assign trial = {2'b00, root[j], 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? (F+2)'(cand - trial) : cand[F+1:0];
        root[j+1] <= {root[j][F-2:0], ge};
        alt[j+1]  <= alt[j];
        neg[j+1]  <= neg[j];
        uk[j+1]   <= uk[j];
        cc[j+1]   <= cc[j];
        tg[j+1]   <= tg[j];
      end
    end
  end

  assign out_valid = vl[F];
  assign u_out     = neg[F] ? root[F] : alt[F];
  assign c_out     = cc[F];
  assign tag_out   = tg[F];

endmodule
